// ----- sv/cell_wall_ray_and_collision_test_unit_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the cell wall ray and collision test unit
// Shared concurrent assertion forms, clocked on the rising edge and
// disabled while the synchronous reset is held.
// ----------------------------------------------------------------------------
`ifndef CELL_WALL_RAY_AND_COLLISION_TEST_UNIT_MACROS_SVH
`define CELL_WALL_RAY_AND_COLLISION_TEST_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CWR_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cwr assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define CWR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cwr assertion failed");

`endif

// ----- sv/cwr_pkg.sv -----
// ----------------------------------------------------------------------------
// cwr_pkg
// Types, constants and the quarter-wave sine generator of the cell wall
// ray and collision test unit.
// ----------------------------------------------------------------------------
`default_nettype none

package cwr_pkg;

  localparam int DEF_ANGLE_BITS    = 12;
  localparam int DEF_POS_FRAC_BITS = 4;

  localparam int POS_W  = 17;  // positions and origins
  localparam int LOC_W  = 18;  // offsets from the cell centre
  localparam int MAG_W  = 15;  // Q2.14 table magnitude, 0 .. 16384
  localparam int HS_W   = 17;  // half span constant, signed
  localparam int PROD_W = 34;
  localparam int DIFF_W = 35;
  localparam int SUM_W  = 36;
  localparam int CFG_W  = 17;
  localparam int MASK_W = 4;

  localparam int HALF_SPAN_MM = 84;
  localparam int CLEAR_MM     = 90;
  localparam int LIMIT_MM     = 51;
  localparam int MIN_MAG      = 2;
  localparam int ONE_Q14      = 16384;

  localparam longint unsigned PI_HALF_Q30 = 64'd1686629713;

  // Wall bit positions in wall_mask.
  localparam int WALL_N = 0;
  localparam int WALL_W = 1;
  localparam int WALL_E = 2;
  localparam int WALL_S = 3;

  typedef enum logic [1:0] {
    CFG_WALL_MASK = 2'd0,
    CFG_ORIGIN_X  = 2'd1,
    CFG_ORIGIN_Y  = 2'd2
  } cfg_idx_t;

  // Quarter-wave sine entry in Q2.14, built from a Taylor series in Q30.
  function automatic logic [MAG_W-1:0] quarter_sine(int unsigned idx, int unsigned qbits);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned sum;
    longint unsigned r;
    x    = (longint'(idx) * PI_HALF_Q30 + (64'd1 << (qbits - 1))) >> qbits;
    x2   = (x * x) >> 30;
    term = x;
    sum  = x;
    term = ((term * x2) >> 30) / 6;
    sum  = sum - term;
    term = ((term * x2) >> 30) / 20;
    sum  = sum + term;
    term = ((term * x2) >> 30) / 42;
    sum  = sum - term;
    term = ((term * x2) >> 30) / 72;
    sum  = sum + term;
    term = ((term * x2) >> 30) / 110;
    sum  = sum - term;
    term = ((term * x2) >> 30) / 156;
    sum  = sum + term;
    r = (sum + 64'd32768) >> 16;
    if (r > longint'(ONE_Q14)) begin
      r = longint'(ONE_Q14);
    end
    return MAG_W'(r);
  endfunction

endpackage

`default_nettype wire

// ----- sv/cwr_in_if.sv -----
// ----------------------------------------------------------------------------
// cwr_in_if
// Pose channel: previous and current position and the heading.
// ----------------------------------------------------------------------------
`default_nettype none

interface cwr_in_if #(
  parameter int ANGLE_BITS = cwr_pkg::DEF_ANGLE_BITS
);
  import cwr_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [POS_W-1:0] prev_x;
  logic signed [POS_W-1:0] prev_y;
  logic signed [POS_W-1:0] pos_x;
  logic signed [POS_W-1:0] pos_y;
  logic [ANGLE_BITS-1:0]   heading;

  modport source (output valid, prev_x, prev_y, pos_x, pos_y, heading, input ready);
  modport sink   (input valid, prev_x, prev_y, pos_x, pos_y, heading, output ready);
endinterface

`default_nettype wire

// ----- sv/cwr_out_if.sv -----
// ----------------------------------------------------------------------------
// cwr_out_if
// Result channel: ray hit and the four collision flags.
// ----------------------------------------------------------------------------
`default_nettype none

interface cwr_out_if;
  logic valid;
  logic ready;
  logic faces_wall;
  logic hit_east;
  logic hit_west;
  logic hit_north;
  logic hit_south;

  modport source (output valid, faces_wall, hit_east, hit_west, hit_north, hit_south,
                  input ready);
  modport sink   (input valid, faces_wall, hit_east, hit_west, hit_north, hit_south,
                  output ready);
endinterface

`default_nettype wire

// ----- sv/cwr_cfg_if.sv -----
// ----------------------------------------------------------------------------
// cwr_cfg_if
// Register write channel: register index and write data.
// ----------------------------------------------------------------------------
`default_nettype none

interface cwr_cfg_if;
  import cwr_pkg::*;

  logic             valid;
  logic             ready;
  logic [1:0]       index;
  logic [CFG_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- sv/cell_wall_ray_and_collision_test_unit.sv -----
// ----------------------------------------------------------------------------
// cell_wall_ray_and_collision_test_unit
// Tests one pose against one square maze cell: ray-to-wall hit along the
// heading and per-direction collision with present walls.
// ----------------------------------------------------------------------------
//
//   Channel  Dir  Transfer payload
//   -------  ---  ---------------------------------------------------------
//   cfg_ch   in   index, data: wall_mask, origin_x, origin_y
//   in_ch    in   prev_x, prev_y, pos_x, pos_y, heading
//   out_ch   out  faces_wall, hit_east, hit_west, hit_north, hit_south
//
// One pose is taken every cycle while the pipeline is not stalled; a result
// is offered once it has passed through five register stages: sine ROM
// read, multipliers, sign and difference, band sums and the compare into
// the output register.
// Reset clears the stage valid bits and the registers; the ROM is constant.
// Each stage holds while the one after it is full and stalled, and empty
// stages fill up, so input is taken while a result waits at the output.
// ----------------------------------------------------------------------------
`default_nettype none

`include "cell_wall_ray_and_collision_test_unit_macros.svh"

module cell_wall_ray_and_collision_test_unit #(
  parameter int ANGLE_BITS    = cwr_pkg::DEF_ANGLE_BITS,
  parameter int POS_FRAC_BITS = cwr_pkg::DEF_POS_FRAC_BITS
) (
  input wire logic clk,
  input wire logic rst_n,
  cwr_cfg_if.sink  cfg_ch,
  cwr_in_if.sink   in_ch,
  cwr_out_if.source out_ch
);
  import cwr_pkg::*;

  localparam int QB     = ANGLE_BITS - 2;
  localparam int ADDR_W = QB + 1;
  localparam int QSIZE  = 1 << QB;

  localparam logic signed [HS_W-1:0]  HALF_SPAN = HS_W'(HALF_SPAN_MM << POS_FRAC_BITS);
  localparam logic signed [LOC_W-1:0] CLOSE     =
      LOC_W'((CLEAR_MM - LIMIT_MM) << POS_FRAC_BITS);

  typedef struct packed {
    logic ok_n;
    logic ok_w;
    logic ok_e;
    logic ok_s;
    logic hit_e;
    logic hit_w;
    logic hit_n;
    logic hit_s;
  } flags_t;

  function automatic logic in_band(logic signed [SUM_W-1:0] v, logic signed [SUM_W-1:0] t);
    return (v <= t) && (v >= -t);
  endfunction

  // Registers.
  logic [MASK_W-1:0]       wall_mask_r;
  logic signed [POS_W-1:0] origin_x_r;
  logic signed [POS_W-1:0] origin_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wall_mask_r <= '0;
      origin_x_r  <= '0;
      origin_y_r  <= '0;
    end else if (cfg_ch.valid) begin
      case (cfg_idx_t'(cfg_ch.index))
        CFG_WALL_MASK: wall_mask_r <= cfg_ch.data[MASK_W-1:0];
        CFG_ORIGIN_X:  origin_x_r  <= $signed(cfg_ch.data[POS_W-1:0]);
        CFG_ORIGIN_Y:  origin_y_r  <= $signed(cfg_ch.data[POS_W-1:0]);
        default: ;
      endcase
    end
  end

  assign cfg_ch.ready = 1'b1;

  // Stage readiness, from the output backwards.
  logic v1_r, v2_r, v3_r, v4_r, out_valid_r;
  logic rdy1, rdy2, rdy3, rdy4, rdy5;

  assign rdy5 = !out_valid_r || out_ch.ready;
  assign rdy4 = !v4_r || rdy5;
  assign rdy3 = !v3_r || rdy4;
  assign rdy2 = !v2_r || rdy3;
  assign rdy1 = !v1_r || rdy2;
  assign in_ch.ready = rdy1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_ch.valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
      if (rdy5) out_valid_r <= v4_r;
    end
  end

  // Stage 1: table addresses, local offsets, move directions.
  logic [ANGLE_BITS-1:0] head_s, head_c;
  logic [ADDR_W-1:0]     addr_s, addr_c;
  logic [MAG_W-1:0]      mag_s, mag_c;

  assign head_s = in_ch.heading;
  assign head_c = in_ch.heading + ANGLE_BITS'(QSIZE);
  assign addr_s = head_s[QB] ? ADDR_W'(QSIZE) - {1'b0, head_s[QB-1:0]}
                             : {1'b0, head_s[QB-1:0]};
  assign addr_c = head_c[QB] ? ADDR_W'(QSIZE) - {1'b0, head_c[QB-1:0]}
                             : {1'b0, head_c[QB-1:0]};

  cwr_sine_rom #(
    .ANGLE_BITS (ANGLE_BITS)
  ) u_rom (
    .clk    (clk),
    .en     (rdy1),
    .addr_s (addr_s),
    .addr_c (addr_c),
    .mag_s  (mag_s),
    .mag_c  (mag_c)
  );

  logic signed [LOC_W-1:0] lx1_r, ly1_r, lx1_nxt, ly1_nxt;
  logic                    sneg1_r, cneg1_r;
  logic                    ltx1_r, gtx1_r, lty1_r, gty1_r;

  assign lx1_nxt = LOC_W'(in_ch.pos_x) - LOC_W'(origin_x_r);
  assign ly1_nxt = LOC_W'(in_ch.pos_y) - LOC_W'(origin_y_r);

  always_ff @(posedge clk) begin
    if (rdy1) begin
      lx1_r   <= lx1_nxt;
      ly1_r   <= ly1_nxt;
      sneg1_r <= head_s[ANGLE_BITS-1];
      cneg1_r <= head_c[ANGLE_BITS-1];
      ltx1_r  <= in_ch.prev_x < in_ch.pos_x;
      gtx1_r  <= in_ch.prev_x > in_ch.pos_x;
      lty1_r  <= in_ch.prev_y < in_ch.pos_y;
      gty1_r  <= in_ch.prev_y > in_ch.pos_y;
    end
  end

  // Stage 2: products on table magnitudes, wall enables, collision flags.
  logic signed [PROD_W-1:0] p1m2_r, p2m2_r, am2_r, bm2_r;
  logic signed [PROD_W-1:0] p1m2_nxt, p2m2_nxt, am2_nxt, bm2_nxt;
  logic                     sneg2_r, cneg2_r;
  flags_t                   flags2_r, flags2_nxt;
  logic                     s_big, c_big;

  assign s_big = mag_s >= MAG_W'(MIN_MAG);
  assign c_big = mag_c >= MAG_W'(MIN_MAG);

  assign p1m2_nxt = PROD_W'(lx1_r) * PROD_W'($signed({1'b0, mag_s}));
  assign p2m2_nxt = PROD_W'(ly1_r) * PROD_W'($signed({1'b0, mag_c}));
  assign am2_nxt  = PROD_W'(HALF_SPAN) * PROD_W'($signed({1'b0, mag_s}));
  assign bm2_nxt  = PROD_W'(HALF_SPAN) * PROD_W'($signed({1'b0, mag_c}));

  always_comb begin
    flags2_nxt.ok_n  = wall_mask_r[WALL_N] && !sneg1_r && s_big;
    flags2_nxt.ok_s  = wall_mask_r[WALL_S] &&  sneg1_r && s_big;
    flags2_nxt.ok_e  = wall_mask_r[WALL_E] && !cneg1_r && c_big;
    flags2_nxt.ok_w  = wall_mask_r[WALL_W] &&  cneg1_r && c_big;
    flags2_nxt.hit_e = ltx1_r && wall_mask_r[WALL_E] && (lx1_r > CLOSE);
    flags2_nxt.hit_w = gtx1_r && wall_mask_r[WALL_W] && (lx1_r < -CLOSE);
    flags2_nxt.hit_n = lty1_r && wall_mask_r[WALL_N] && (ly1_r > CLOSE);
    flags2_nxt.hit_s = gty1_r && wall_mask_r[WALL_S] && (ly1_r < -CLOSE);
  end

  always_ff @(posedge clk) begin
    if (rdy2) begin
      p1m2_r   <= p1m2_nxt;
      p2m2_r   <= p2m2_nxt;
      am2_r    <= am2_nxt;
      bm2_r    <= bm2_nxt;
      sneg2_r  <= sneg1_r;
      cneg2_r  <= cneg1_r;
      flags2_r <= flags2_nxt;
    end
  end

  // Stage 3: apply the quadrant signs and form lx*S - ly*C.
  logic signed [PROD_W-1:0] p1_3, p2_3;
  logic signed [DIFF_W-1:0] d3_r, d3_nxt;
  logic signed [PROD_W-1:0] a3_r, b3_r, a3_nxt, b3_nxt;
  flags_t                   flags3_r;

  assign p1_3   = sneg2_r ? -p1m2_r : p1m2_r;
  assign p2_3   = cneg2_r ? -p2m2_r : p2m2_r;
  assign d3_nxt = DIFF_W'(p1_3) - DIFF_W'(p2_3);
  assign a3_nxt = sneg2_r ? -am2_r : am2_r;
  assign b3_nxt = cneg2_r ? -bm2_r : bm2_r;

  always_ff @(posedge clk) begin
    if (rdy3) begin
      d3_r     <= d3_nxt;
      a3_r     <= a3_nxt;
      b3_r     <= b3_nxt;
      flags3_r <= flags2_r;
    end
  end

  // Stage 4: the signed distance along each wall, scaled by the divisor.
  logic signed [SUM_W-1:0] sum_n4_r, sum_w4_r, sum_e4_r, sum_s4_r;
  logic signed [SUM_W-1:0] a4_r, b4_r;
  flags_t                  flags4_r;

  always_ff @(posedge clk) begin
    if (rdy4) begin
      sum_n4_r <= SUM_W'(d3_r) + SUM_W'(b3_r);
      sum_w4_r <= SUM_W'(d3_r) + SUM_W'(a3_r);
      sum_e4_r <= SUM_W'(d3_r) - SUM_W'(a3_r);
      sum_s4_r <= SUM_W'(d3_r) - SUM_W'(b3_r);
      a4_r     <= SUM_W'(a3_r);
      b4_r     <= SUM_W'(b3_r);
      flags4_r <= flags3_r;
    end
  end

  // Output register.
  logic faces_wall_r, faces_wall_nxt;
  logic hit_east_r, hit_west_r, hit_north_r, hit_south_r;

  assign faces_wall_nxt = (flags4_r.ok_n && in_band(sum_n4_r,  a4_r)) ||
                          (flags4_r.ok_w && in_band(sum_w4_r, -b4_r)) ||
                          (flags4_r.ok_e && in_band(sum_e4_r,  b4_r)) ||
                          (flags4_r.ok_s && in_band(sum_s4_r, -a4_r));

  always_ff @(posedge clk) begin
    if (rdy5) begin
      faces_wall_r <= faces_wall_nxt;
      hit_east_r   <= flags4_r.hit_e;
      hit_west_r   <= flags4_r.hit_w;
      hit_north_r  <= flags4_r.hit_n;
      hit_south_r  <= flags4_r.hit_s;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.faces_wall = faces_wall_r;
  assign out_ch.hit_east   = hit_east_r;
  assign out_ch.hit_west   = hit_west_r;
  assign out_ch.hit_north  = hit_north_r;
  assign out_ch.hit_south  = hit_south_r;

  // A move goes one way along an axis, so opposite flags never pair up.
  `CWR_ASSERT_SAME(a_no_east_west, clk, rst_n, out_valid_r, !(hit_east_r && hit_west_r))
  `CWR_ASSERT_SAME(a_no_north_south, clk, rst_n, out_valid_r, !(hit_north_r && hit_south_r))
  `CWR_ASSERT_NEXT(a_accept_fills, clk, rst_n, in_ch.valid && rdy1, v1_r)
  `CWR_ASSERT_NEXT(a_stall_keeps, clk, rst_n, v4_r && !rdy5, v4_r && $stable(sum_n4_r))

endmodule

`default_nettype wire

// ----- sv/cwr_sine_rom.sv -----
// ----------------------------------------------------------------------------
// cwr_sine_rom
// Dual-read quarter-wave sine ROM with registered read data, filled with
// constants at elaboration.
// ----------------------------------------------------------------------------
`default_nettype none

module cwr_sine_rom #(
  parameter int ANGLE_BITS = cwr_pkg::DEF_ANGLE_BITS
) (
  input  wire logic                       clk,
  input  wire logic                       en,
  input  wire logic [ANGLE_BITS-2:0]      addr_s,
  input  wire logic [ANGLE_BITS-2:0]      addr_c,
  output logic      [cwr_pkg::MAG_W-1:0]  mag_s,
  output logic      [cwr_pkg::MAG_W-1:0]  mag_c
);
  import cwr_pkg::*;

  localparam int QB    = ANGLE_BITS - 2;
  localparam int DEPTH = (1 << QB) + 1;

  typedef logic [MAG_W-1:0] rom_t [DEPTH];

  function automatic rom_t build_rom();
    rom_t tab;
    for (int i = 0; i < DEPTH; i++) begin
      tab[i] = quarter_sine(i, QB);
    end
    return tab;
  endfunction

  localparam rom_t ROM = build_rom();

  logic [MAG_W-1:0] mag_s_r;
  logic [MAG_W-1:0] mag_c_r;

  always_ff @(posedge clk) begin
    if (en) begin
      mag_s_r <= ROM[addr_s];
      mag_c_r <= ROM[addr_c];
    end
  end

  assign mag_s = mag_s_r;
  assign mag_c = mag_c_r;

endmodule

`default_nettype wire

// ----- verif/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: cell wall ray and collision test unit
// Drives poses through the pose channel under several wall and origin settings,
// and compares every result with a predictor in this file or a pinned value.
// A directed table goes first, then random poses under four flow-control mixes.
// ----------------------------------------------------------------------------

module tb;
  import cwr_pkg::*;

  localparam int ANGLE_BITS    = DEF_ANGLE_BITS;
  localparam int POS_FRAC_BITS = DEF_POS_FRAC_BITS;
  localparam int QTR_BITS      = ANGLE_BITS - 2;
  localparam int QTR           = 1 << QTR_BITS;
  localparam int ANGLE_MASK    = (1 << ANGLE_BITS) - 1;
  localparam int UNIT          = 1 << POS_FRAC_BITS;
  localparam int HALF_SPAN     = HALF_SPAN_MM * UNIT;
  localparam int CLEARANCE     = CLEAR_MM * UNIT;
  localparam int CLOSEST       = LIMIT_MM * UNIT;
  localparam int NEAR_EDGE     = CLEARANCE - CLOSEST;
  localparam logic [1:0] CFG_SPARE = 2'd3;  // no register behind this index

  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_ITEMS   = 106;
  localparam int LONG_HOLD     = 80;
  localparam int END_SETTLE    = 20;
  localparam int DRAIN_LIMIT   = 5000;

  typedef struct {
    logic signed [POS_W-1:0] prev_x;
    logic signed [POS_W-1:0] prev_y;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic [ANGLE_BITS-1:0]   heading;
  } pose_t;

  typedef struct packed {
    logic faces_wall;
    logic hit_east;
    logic hit_west;
    logic hit_north;
    logic hit_south;
  } verdict_t;

  typedef struct {
    logic [CFG_W-1:0]        mask_word;
    logic signed [POS_W-1:0] org_x;
    logic signed [POS_W-1:0] org_y;
    pose_t                   pose;
    bit                      pinned;
    verdict_t                want;
  } stim_row_t;

  logic clk;
  logic rst_n;

  cwr_cfg_if                           cfg_ch();
  cwr_in_if #(.ANGLE_BITS(ANGLE_BITS)) in_ch();
  cwr_out_if                           out_ch();

  cell_wall_ray_and_collision_test_unit #(
    .ANGLE_BITS   (ANGLE_BITS),
    .POS_FRAC_BITS(POS_FRAC_BITS)
  ) u_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg_ch(cfg_ch),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  // Predictor state, following the register transfers seen on the bus.
  logic [MASK_W-1:0] wall_bits;
  longint            wall_org_x;
  longint            wall_org_y;
  longint            quarter_wave [0:QTR];
  verdict_t          verdicts_due [$];

  // Sender side bookkeeping, driven together with the pose payload.
  bit                pose_pinned;
  verdict_t          pinned_want;

  // Register words last written by the stimulus.
  logic [CFG_W-1:0]        cur_mask_word;
  logic signed [POS_W-1:0] cur_org_x;
  logic signed [POS_W-1:0] cur_org_y;

  int unsigned tx_idle_pct;
  int unsigned rx_stall_pct;
  int          hold_trigger;
  int          mismatches;
  int          results_seen;
  int          faces_count;
  int          collision_count;
  int          directed_sent;
  int          random_sent;
  int          settings_count;

  stim_row_t directed_rows [$];

  // Quarter-wave sine entry in Q2.14 from a seven-term Taylor series in Q30.
  function automatic longint quarter_entry(int unsigned idx);
    longint unsigned ang;
    longint unsigned ang_sq;
    longint unsigned term;
    longint unsigned acc;
    longint unsigned r;
    ang    = (longint'(idx) * PI_HALF_Q30 + (64'd1 << (QTR_BITS - 1))) >> QTR_BITS;
    ang_sq = (ang * ang) >> 30;
    term   = ang;
    acc    = ang;
    for (int unsigned k = 1; k <= 6; k++) begin
      term = ((term * ang_sq) >> 30) / longint'((2 * k) * (2 * k + 1));
      if (k % 2 == 1) begin
        acc = acc - term;
      end else begin
        acc = acc + term;
      end
    end
    r = (acc + 64'd32768) >> 16;
    if (r > longint'(ONE_Q14)) begin
      r = longint'(ONE_Q14);
    end
    return longint'(r);
  endfunction

  function automatic longint heading_sine(int unsigned h);
    int unsigned quadrant;
    int unsigned idx;
    h        = h & ANGLE_MASK;
    quadrant = h >> QTR_BITS;
    idx      = h & (QTR - 1);
    case (quadrant)
      0: return quarter_wave[idx];
      1: return quarter_wave[QTR - idx];
      2: return -quarter_wave[idx];
      default: return -quarter_wave[QTR - idx];
    endcase
  endfunction

  function automatic longint magnitude(longint v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic verdict_t predict_verdict(pose_t p);
    longint   lx;
    longint   ly;
    longint   s;
    longint   c;
    longint   hs;
    verdict_t v;
    lx = longint'(p.pos_x) - wall_org_x;
    ly = longint'(p.pos_y) - wall_org_y;
    s  = heading_sine(p.heading);
    c  = heading_sine(p.heading + QTR);
    hs = HALF_SPAN;
    // The ray test is on the wall line only, so a wall behind the pose counts.
    v.faces_wall =
      (wall_bits[WALL_N] && s >= MIN_MAG && magnitude(lx * s + (hs - ly) * c) <= hs * s) ||
      (wall_bits[WALL_W] && c <= -MIN_MAG &&
       magnitude(ly * c + (-hs - lx) * s) <= hs * (-c)) ||
      (wall_bits[WALL_E] && c >= MIN_MAG && magnitude(ly * c + (hs - lx) * s) <= hs * c) ||
      (wall_bits[WALL_S] && s <= -MIN_MAG &&
       magnitude(lx * s + (-hs - ly) * c) <= hs * (-s));
    v.hit_east  = (p.prev_x < p.pos_x) && wall_bits[WALL_E] && (CLEARANCE - lx < CLOSEST);
    v.hit_west  = (p.prev_x > p.pos_x) && wall_bits[WALL_W] && (CLEARANCE + lx < CLOSEST);
    v.hit_north = (p.prev_y < p.pos_y) && wall_bits[WALL_N] && (CLEARANCE - ly < CLOSEST);
    v.hit_south = (p.prev_y > p.pos_y) && wall_bits[WALL_S] && (ly + CLEARANCE < CLOSEST);
    return v;
  endfunction

  task automatic report_mismatch(string what, int idx, logic got, logic want);
    $display("MISMATCH result %0d at %0t: %s got %b, expected %b", idx, $time, what, got,
             want);
    mismatches++;
  endtask

  // Register updates, expectation capture and result checking on one edge.
  always @(posedge clk) begin
    pose_t    seen;
    verdict_t got;
    verdict_t exp_v;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.faces_wall, out_ch.hit_east, out_ch.hit_west, out_ch.hit_north,
                out_ch.hit_south};
        if (verdicts_due.size() == 0) begin
          report_mismatch("result with nothing pending", results_seen, 1'b1, 1'b0);
        end else begin
          exp_v = verdicts_due.pop_front();
          if (got.faces_wall !== exp_v.faces_wall)
            report_mismatch("faces_wall", results_seen, got.faces_wall, exp_v.faces_wall);
          if (got.hit_east !== exp_v.hit_east)
            report_mismatch("hit_east", results_seen, got.hit_east, exp_v.hit_east);
          if (got.hit_west !== exp_v.hit_west)
            report_mismatch("hit_west", results_seen, got.hit_west, exp_v.hit_west);
          if (got.hit_north !== exp_v.hit_north)
            report_mismatch("hit_north", results_seen, got.hit_north, exp_v.hit_north);
          if (got.hit_south !== exp_v.hit_south)
            report_mismatch("hit_south", results_seen, got.hit_south, exp_v.hit_south);
        end
        if (got.faces_wall === 1'b1) faces_count++;
        if (|got[3:0] === 1'b1) collision_count++;
        results_seen++;
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          CFG_WALL_MASK: wall_bits  = cfg_ch.data[MASK_W-1:0];
          CFG_ORIGIN_X:  wall_org_x = longint'($signed(cfg_ch.data));
          CFG_ORIGIN_Y:  wall_org_y = longint'($signed(cfg_ch.data));
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) begin
        seen = '{in_ch.prev_x, in_ch.prev_y, in_ch.pos_x, in_ch.pos_y, in_ch.heading};
        verdicts_due = {verdicts_due, (pose_pinned ? pinned_want : predict_verdict(seen))};
      end
    end
  end

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver: random stalls, plus a long hold-off whenever one is requested.
  initial begin
    int hold_seen;
    int hold_left;
    hold_seen    = 0;
    hold_left    = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_trigger != hold_seen) begin
        hold_seen = hold_trigger;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  initial begin
    #3ms;
    $display("Timeout with %0d results still pending", verdicts_due.size());
    $display("CHECKS FAILED");
    $finish;
  end

  // Called right after an accepting edge, or with the pose channel idle.
  task automatic send_pose(pose_t p, bit pinned, verdict_t want);
    @(negedge clk);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.prev_x  <= p.prev_x;
    in_ch.prev_y  <= p.prev_y;
    in_ch.pos_x   <= p.pos_x;
    in_ch.pos_y   <= p.pos_y;
    in_ch.heading <= p.heading;
    pose_pinned   <= pinned;
    pinned_want   <= want;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // Stops offering poses and waits for every outstanding result.
  task automatic drain_results();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (verdicts_due.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [CFG_W-1:0] data);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic apply_setting(logic [CFG_W-1:0] mask_word, logic signed [POS_W-1:0] ox,
                               logic signed [POS_W-1:0] oy);
    drain_results();
    write_reg(CFG_WALL_MASK, mask_word);
    write_reg(CFG_ORIGIN_X, ox);
    write_reg(CFG_ORIGIN_Y, oy);
    cur_mask_word = mask_word;
    cur_org_x     = ox;
    cur_org_y     = oy;
    settings_count++;
  endtask

  task automatic add_row(logic [CFG_W-1:0] mask_word, int ox, int oy, int px, int py,
                         int cx, int cy, int hd, bit pinned, logic [4:0] want);
    stim_row_t r;
    r.mask_word    = mask_word;
    r.org_x        = POS_W'(ox);
    r.org_y        = POS_W'(oy);
    r.pose.prev_x  = POS_W'(px);
    r.pose.prev_y  = POS_W'(py);
    r.pose.pos_x   = POS_W'(cx);
    r.pose.pos_y   = POS_W'(cy);
    r.pose.heading = ANGLE_BITS'(hd);
    r.pinned       = pinned;
    r.want         = want;
    directed_rows  = {directed_rows, r};
  endtask

  // Offsets that sit on the collision threshold, the wall ends, the wall line or the centre.
  function automatic int edge_offset();
    int d;
    case ($urandom_range(5))
      0: d = NEAR_EDGE;
      1: d = NEAR_EDGE + 1;
      2: d = HALF_SPAN;
      3: d = HALF_SPAN + int'($urandom_range(2)) - 1;
      4: d = 0;
      default: d = CLEARANCE;
    endcase
    return $urandom_range(1) ? d : -d;
  endfunction

  function automatic pose_t rand_pose();
    pose_t p;
    int    sel;
    int    lx;
    int    ly;
    int    dx;
    int    dy;
    sel = $urandom_range(99);
    if (sel < 30) begin
      p.prev_x  = POS_W'($urandom);
      p.prev_y  = POS_W'($urandom);
      p.pos_x   = POS_W'($urandom);
      p.pos_y   = POS_W'($urandom);
      p.heading = ANGLE_BITS'($urandom);
      return p;
    end
    if (sel < 75) begin
      lx = int'($urandom_range(4400)) - 2200;
      ly = int'($urandom_range(4400)) - 2200;
    end else begin
      lx = edge_offset();
      ly = edge_offset();
    end
    dx = ($urandom_range(7) == 0) ? 0 : int'($urandom_range(800)) - 400;
    dy = ($urandom_range(7) == 0) ? 0 : int'($urandom_range(800)) - 400;
    p.pos_x  = POS_W'(int'(cur_org_x) + lx);
    p.pos_y  = POS_W'(int'(cur_org_y) + ly);
    p.prev_x = POS_W'(int'(cur_org_x) + lx - dx);
    p.prev_y = POS_W'(int'(cur_org_y) + ly - dy);
    if ($urandom_range(6) == 0) begin
      p.heading = ANGLE_BITS'(int'($urandom_range(3)) * QTR + int'($urandom_range(4)) - 2);
    end else begin
      p.heading = ANGLE_BITS'($urandom);
    end
    return p;
  endfunction

  initial begin
    int          mode;
    logic [CFG_W-1:0] mask_word;
    logic signed [POS_W-1:0] ox;
    logic signed [POS_W-1:0] oy;
    int          spin;
    rst_n         = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.prev_x  = '0;
    in_ch.prev_y  = '0;
    in_ch.pos_x   = '0;
    in_ch.pos_y   = '0;
    in_ch.heading = '0;
    cfg_ch.valid  = 1'b0;
    cfg_ch.index  = CFG_WALL_MASK;
    cfg_ch.data   = '0;
    pose_pinned   = 1'b0;
    pinned_want   = '0;
    wall_bits     = '0;
    wall_org_x    = 0;
    wall_org_y    = 0;
    cur_mask_word = '0;
    cur_org_x     = '0;
    cur_org_y     = '0;
    tx_idle_pct   = 0;
    rx_stall_pct  = 0;
    hold_trigger  = 0;
    mismatches    = 0;
    results_seen  = 0;
    faces_count   = 0;
    collision_count = 0;
    directed_sent = 0;
    random_sent   = 0;
    settings_count = 0;
    for (int i = 0; i <= QTR; i++) begin
      quarter_wave[i] = quarter_entry(i);
    end

    // Reset settings: no wall, so nothing can be hit.
    add_row(17'h0, 0, 0, 0, 0, 0, 0, 0, 1, 5'b00000);
    add_row(17'h0, 0, 0, 65535, 65535, -65536, -65536, 4095, 1, 5'b00000);
    // All walls; the mask word carries bits above the mask, which are dropped.
    add_row(17'h1FFFF, 0, 0, 0, 0, 0, 0, 0, 1, 5'b10000);
    add_row(17'h1FFFF, 0, 0, 0, 0, 0, 0, QTR, 1, 5'b10000);
    add_row(17'h1FFFF, 0, 0, 0, 0, 0, 0, 2 * QTR, 1, 5'b10000);
    add_row(17'h1FFFF, 0, 0, 0, 0, 0, 0, 3 * QTR, 1, 5'b10000);
    add_row(17'h1FFFF, 0, 0, 0, 0, CLEARANCE, 0, 0, 1, 5'b11000);
    add_row(17'h1FFFF, 0, 0, 65535, 65535, -65536, -65536, 0, 1, 5'b00101);
    add_row(17'h1FFFF, 0, 0, -65536, -65536, 65535, 65535, QTR, 1, 5'b01010);
    // No move along either axis: no collision flag, whatever the distance.
    // The pose sits beyond the end of the east wall, so the ray misses too.
    add_row(17'h1FFFF, 0, 0, 1400, -1400, 1400, -1400, 0, 1, 5'b00000);
    // Collision thresholds either side of the limit.
    add_row(17'h1FFFF, 0, 0, 0, 0, NEAR_EDGE, NEAR_EDGE, 512, 0, 5'b00000);
    add_row(17'h1FFFF, 0, 0, 0, 0, NEAR_EDGE + 1, NEAR_EDGE + 1, 512, 0, 5'b00000);
    add_row(17'h1FFFF, 0, 0, 0, 0, -NEAR_EDGE - 1, -NEAR_EDGE - 1, 2560, 0, 5'b00000);
    add_row(17'h1FFFF, 0, 0, 0, 0, -NEAR_EDGE, -NEAR_EDGE, 2560, 0, 5'b00000);
    add_row(17'h1FFFF, 0, 0, 0, 0, 300, HALF_SPAN, QTR - 1, 0, 5'b00000);
    add_row(17'h1FFFF, 0, 0, 0, 0, -300, -HALF_SPAN, 4095, 0, 5'b00000);
    // East wall only, with the pose beyond it: the wall lies behind the ray.
    add_row(17'h4, 0, 0, 0, 0, 2000, 100, 5, 0, 5'b00000);
    add_row(17'h4, 0, 0, 0, 0, 2000, 100, 2 * QTR + 1, 0, 5'b00000);
    // Origin at the extremes of its range.
    add_row(17'hF, -65536, 65535, 0, 0, -65536, 65535, 0, 1, 5'b10000);
    add_row(17'hF, -65536, 65535, -65536, 65535, 65535, -65536, 1536, 0, 5'b00000);
    add_row(17'h9, 65535, -65536, 65535, -65536, -65536, 65535, 1, 0, 5'b00000);
    add_row(17'h6, 65535, -65536, 100, 200, 65000, -65000, 2047, 0, 5'b00000);
    add_row(17'h6, 65535, -65536, 65000, -65000, 64000, -64000, 2049, 0, 5'b00000);

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].mask_word != cur_mask_word || directed_rows[i].org_x != cur_org_x
          || directed_rows[i].org_y != cur_org_y) begin
        apply_setting(directed_rows[i].mask_word, directed_rows[i].org_x,
                      directed_rows[i].org_y);
      end
      send_pose(directed_rows[i].pose, directed_rows[i].pinned, directed_rows[i].want);
      directed_sent++;
    end

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      mode = ph % 4;
      mask_word = CFG_W'($urandom);
      ox        = POS_W'($urandom);
      oy        = POS_W'($urandom);
      case (ph)
        0: begin mask_word = 17'hF; ox = '0; oy = '0; end
        1: begin ox = -65536; oy = 65535; end
        2: begin mask_word = 17'hF; ox = 65535; oy = -65536; end
        3: mask_word = 17'h10;
        default: ;
      endcase
      apply_setting(mask_word, ox, oy);
      if (ph == 4) begin
        write_reg(CFG_SPARE, CFG_W'($urandom));
      end
      case (mode)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 86; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 86; end
        default: begin tx_idle_pct = 30; rx_stall_pct = 30; end
      endcase
      // Hold the result side off while poses keep coming, so the pipe backs up.
      if (mode == 0) hold_trigger++;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (mode == 0 && n == PHASE_ITEMS / 2) drain_results();
        send_pose(rand_pose(), 1'b0, '0);
        random_sent++;
      end
    end

    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    @(negedge clk);
    in_ch.valid <= 1'b0;
    spin = 0;
    while (verdicts_due.size() != 0 && spin < DRAIN_LIMIT) begin
      @(posedge clk);
      spin++;
    end
    repeat (END_SETTLE) @(posedge clk);
    if (verdicts_due.size() != 0) begin
      report_mismatch("results never delivered", results_seen, 1'b0, 1'b1);
    end

    $display("Covered %0d poses (%0d directed, %0d random) over %0d register settings",
             directed_sent + random_sent, directed_sent, random_sent, settings_count);
    $display("and four flow-control mixes: %0d ray hits, %0d collisions, %0d mismatches.",
             faces_count, collision_count, mismatches);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
